>>> hw/rtl/tlg_pkg.sv
// Shared types and constants for the trajectory lookahead goal-distance scorer.
// No dependencies; imported by the controller, datapath and top level.
package tlg_pkg;

  localparam int POS_WIDTH_DEF = 32;
  localparam int TIME_W        = 46;
  localparam int LK_W          = 36;

  localparam logic [TIME_W-1:0] NS_PER_SEC      = 46'd1000000000;
  localparam logic [31:0]       ACT_DIST_RESET  = 32'd9830;
  localparam logic [LK_W-1:0]   LOOKAHEAD_RESET = 36'd500000000;

  // register indexes, byte address is 8 * index
  localparam logic [2:0] REG_GOAL_X    = 3'd0;
  localparam logic [2:0] REG_GOAL_Y    = 3'd1;
  localparam logic [2:0] REG_ROBOT_X   = 3'd2;
  localparam logic [2:0] REG_ROBOT_Y   = 3'd3;
  localparam logic [2:0] REG_ACT_DIST  = 3'd4;
  localparam logic [2:0] REG_LOOKAHEAD = 3'd5;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_MISMATCH = 2'd1,
    ERR_UNTIMED  = 2'd2,
    ERR_TIME     = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    MUL_AX_ACT  = 3'd0,
    MUL_AY_ACT  = 3'd1,
    MUL_ACT_A   = 3'd2,
    MUL_AX_GOAL = 3'd3,
    MUL_AY_GOAL = 3'd4
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     acc_ld;
    logic     acc_add;
    logic     act_latch;
    logic     eval;
    logic     div_step;
    logic     div_fin;
    logic     sq_init;
    logic     sq_step;
    logic     out_load;
  } tlg_cmd_t;

  typedef struct packed {
    logic first_point;
    logic last;
    logic need_div;
    logic div_last;
    logic sq_last;
    logic out_free;
  } tlg_sts_t;

endpackage

>>> hw/rtl/tlg_ctrl.sv
// Sequencer for the scorer: one-hot state machine issuing datapath commands.
// Depends on tlg_pkg (command and status structs).
module tlg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tlg_pkg::tlg_sts_t sts,
  output tlg_pkg::tlg_cmd_t cmd
);
  import tlg_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_ACT0  = 14'b00000000000010,
    S_ACT1  = 14'b00000000000100,
    S_ACT2  = 14'b00000000001000,
    S_ACT3  = 14'b00000000010000,
    S_EVAL  = 14'b00000000100000,
    S_DIV   = 14'b00000001000000,
    S_DIVF  = 14'b00000010000000,
    S_DIST0 = 14'b00000100000000,
    S_DIST1 = 14'b00001000000000,
    S_DIST2 = 14'b00010000000000,
    S_SQI   = 14'b00100000000000,
    S_SQ    = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.mul_sel     = MUL_AX_ACT;
    cmd.load        = accept;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = sts.first_point ? S_ACT0 : S_EVAL;
        end
      end
      S_ACT0: begin
        cmd.mul_sel = MUL_AX_ACT;
        state_nxt   = S_ACT1;
      end
      S_ACT1: begin
        cmd.mul_sel = MUL_AY_ACT;
        cmd.acc_ld  = 1'b1;
        state_nxt   = S_ACT2;
      end
      S_ACT2: begin
        cmd.mul_sel = MUL_ACT_A;
        cmd.acc_add = 1'b1;
        state_nxt   = S_ACT3;
      end
      S_ACT3: begin
        cmd.act_latch = 1'b1;
        state_nxt     = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.need_div) begin
          state_nxt = S_DIV;
        end else if (sts.last) begin
          state_nxt = S_DIST0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DIVF;
        end
      end
      S_DIVF: begin
        cmd.div_fin = 1'b1;
        state_nxt   = sts.last ? S_DIST0 : S_IDLE;
      end
      S_DIST0: begin
        cmd.mul_sel = MUL_AX_GOAL;
        state_nxt   = S_DIST1;
      end
      S_DIST1: begin
        cmd.mul_sel = MUL_AY_GOAL;
        cmd.acc_ld  = 1'b1;
        state_nxt   = S_DIST2;
      end
      S_DIST2: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_SQI;
      end
      S_SQI: begin
        cmd.sq_init = 1'b1;
        state_nxt   = S_SQ;
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        if (sts.sq_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input taken while a word is still being worked on");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an unread word");

  a_sq_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sq_step && sts.sq_last) |=> (state_r == S_FIN))
    else $error("root sequence did not finish into the output stage");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && sts.div_last) |=> cmd.div_fin)
    else $error("interpolation result not written after last step");
`endif

endmodule

>>> hw/rtl/tlg_lerp.sv
// One interpolation lane: start + round(delta*num/den), one bit of delta per step.
// No package dependencies; instantiated twice by tlg_datapath.
module tlg_lerp #(
  parameter int PW = 32,
  parameter int TW = 46
) (
  input  logic          clk,
  input  logic          load,
  input  logic          step,
  input  logic [PW-1:0] start_v,
  input  logic [PW-1:0] end_v,
  input  logic [TW-1:0] num,
  input  logic [TW-1:0] den,
  output logic [PW-1:0] res
);
  localparam int QW = PW + 2;

  logic [PW:0]   delta, mag;
  logic [PW:0]   m_r;
  logic          neg_r;
  logic [PW-1:0] base_r;
  logic [TW-1:0] r_r;
  logic [QW-1:0] q_r;
  logic [TW+1:0] r1, den1, den2;
  logic [TW+1:0] r_nxt;
  logic [1:0]    k;
  logic          rnd;
  logic [QW-1:0] qf, base_ext, sum;

  assign delta = {end_v[PW-1], end_v} - {start_v[PW-1], start_v};
  assign mag   = delta[PW] ? (~delta + 1'b1) : delta;

  // r stays below den, so 2r+num stays below 3den: at most two subtractions
  assign den1 = {2'b00, den};
  assign den2 = {1'b0, den, 1'b0};
  assign r1   = {1'b0, r_r, 1'b0} + (m_r[PW] ? {2'b00, num} : '0);

  always_comb begin
    if (r1 >= den2) begin
      r_nxt = r1 - den2;
      k     = 2'd2;
    end else if (r1 >= den1) begin
      r_nxt = r1 - den1;
      k     = 2'd1;
    end else begin
      r_nxt = r1;
      k     = 2'd0;
    end
  end

  // round half away: 2r >= den
  assign rnd      = ({1'b0, r_r, 1'b0} >= den1);
  assign qf       = q_r + QW'(rnd);
  assign base_ext = {{2{base_r[PW-1]}}, base_r};
  assign sum      = neg_r ? (base_ext - qf) : (base_ext + qf);
  assign res      = sum[PW-1:0];

  always_ff @(posedge clk) begin
    if (load) begin
      m_r    <= mag;
      neg_r  <= delta[PW];
      base_r <= start_v;
      r_r    <= '0;
      q_r    <= '0;
    end else if (step) begin
      m_r <= {m_r[PW-1:0], 1'b0};
      r_r <= r_nxt[TW-1:0];
      q_r <= {q_r[QW-2:0], 1'b0} + QW'(k);
    end
  end

endmodule

>>> hw/rtl/tlg_datapath.sv
// Datapath: item registers, trajectory state, shared squarer, lerp lanes, root unit.
// Depends on tlg_pkg and tlg_lerp.
module tlg_datapath #(
  parameter int PW = tlg_pkg::POS_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tlg_pkg::tlg_cmd_t       cmd,
  output tlg_pkg::tlg_sts_t       sts,
  input  logic [PW-1:0]           goal_x,
  input  logic [PW-1:0]           goal_y,
  input  logic [PW-1:0]           robot_x,
  input  logic [PW-1:0]           robot_y,
  input  logic [31:0]             act_dist,
  input  logic [tlg_pkg::LK_W-1:0] lookahead,
  input  logic [PW-1:0]           pt_x,
  input  logic [PW-1:0]           pt_y,
  input  logic [15:0]             pt_heading,
  input  logic [15:0]             pt_sec,
  input  logic [29:0]             pt_nsec,
  input  logic                    pt_timed,
  input  logic                    pt_last,
  input  logic                    out_tready,
  output logic                    out_tvalid,
  output logic [31:0]             out_score,
  output logic [1:0]              out_err,
  output logic                    out_active
);
  import tlg_pkg::*;

  localparam int MW = PW + 1;
  localparam int EW = (MW > 32) ? MW : 33;
  localparam int CW = $clog2(PW + 1);

  // item
  logic [PW-1:0]     px_r, py_r;
  logic [15:0]       hd_r;
  logic              timed_r, last_r, badt_r;
  logic [TIME_W-1:0] t_r;
  // trajectory
  logic [PW-1:0]     prev_x_r, prev_y_r, proj_x_r, proj_y_r;
  logic [15:0]       prev_hd_r;
  logic [TIME_W-1:0] prev_t_r;
  logic              proj_found_r, first_r, untimed_r, active_r;
  err_t              err_r, err_nxt;
  // lerp control
  logic [TIME_W-1:0] num_r, den_r;
  logic [CW-1:0]     cnt_r;
  logic [PW-1:0]     lerp_x, lerp_y;
  // squarer
  logic [31:0]       mul_op;
  logic [63:0]       prod_r;
  logic [64:0]       acc_r;
  // root
  logic [63:0]       rad_r;
  logic [33:0]       rem_r;
  logic [31:0]       root_r;
  logic [4:0]        sqcnt_r;
  logic              sat_r;
  // output
  logic              out_valid_r;
  logic [31:0]       score_r;
  logic [1:0]        oerr_r;
  logic              oact_r;

  // time of the incoming point, modulo 2^46
  logic [TIME_W-1:0] sec_ext, t_in;
  assign sec_ext = {{(TIME_W-16){pt_sec[15]}}, pt_sec};
  assign t_in    = sec_ext * NS_PER_SEC + {{(TIME_W-30){1'b0}}, pt_nsec};

  // magnitudes for the activation test and the goal distance
  logic [MW-1:0] dxa, dya, dxg, dyg, axa_m, aya_m, axg_m, ayg_m;
  logic [EW-1:0] axa, aya, axg, ayg, a_ext;
  logic [PW-1:0] pose_x, pose_y;
  logic          big_act, big_goal;

  assign pose_x = proj_found_r ? proj_x_r : prev_x_r;
  assign pose_y = proj_found_r ? proj_y_r : prev_y_r;
  assign dxa = {goal_x[PW-1], goal_x} - {robot_x[PW-1], robot_x};
  assign dya = {goal_y[PW-1], goal_y} - {robot_y[PW-1], robot_y};
  assign dxg = {goal_x[PW-1], goal_x} - {pose_x[PW-1], pose_x};
  assign dyg = {goal_y[PW-1], goal_y} - {pose_y[PW-1], pose_y};
  assign axa_m = dxa[MW-1] ? (~dxa + 1'b1) : dxa;
  assign aya_m = dya[MW-1] ? (~dya + 1'b1) : dya;
  assign axg_m = dxg[MW-1] ? (~dxg + 1'b1) : dxg;
  assign ayg_m = dyg[MW-1] ? (~dyg + 1'b1) : dyg;
  assign axa   = EW'(axa_m);
  assign aya   = EW'(aya_m);
  assign axg   = EW'(axg_m);
  assign ayg   = EW'(ayg_m);
  assign a_ext = EW'(act_dist);
  assign big_act  = (axa > a_ext) || (aya > a_ext);
  assign big_goal = (|axg[EW-1:32]) || (|ayg[EW-1:32]);

  always_comb begin
    case (cmd.mul_sel)
      MUL_AX_ACT:  mul_op = axa[31:0];
      MUL_AY_ACT:  mul_op = aya[31:0];
      MUL_ACT_A:   mul_op = act_dist;
      MUL_AX_GOAL: mul_op = axg[31:0];
      MUL_AY_GOAL: mul_op = ayg[31:0];
      default:     mul_op = '0;
    endcase
  end

  // per-point checks
  logic [TIME_W-1:0] lk_ext;
  logic              lk_le_t, t_gt_prev, e1, e2, e3, need_div;
  assign lk_ext    = {{(TIME_W-LK_W){1'b0}}, lookahead};
  assign lk_le_t   = lk_ext <= t_r;
  assign t_gt_prev = t_r > prev_t_r;
  assign need_div  = timed_r && !first_r && !proj_found_r && lk_le_t && t_gt_prev;
  assign e3 = timed_r && (badt_r || (!first_r && !t_gt_prev));
  assign e1 = timed_r ? untimed_r : (!last_r || first_r || untimed_r);
  assign e2 = !timed_r && !e1 &&
              ((px_r != prev_x_r) || (py_r != prev_y_r) || (hd_r != prev_hd_r));

  function automatic err_t raise_err(err_t cur, err_t code);
    if (cur == ERR_NONE || code < cur) begin
      return code;
    end
    return cur;
  endfunction

  always_comb begin
    err_nxt = err_r;
    if (e3) err_nxt = raise_err(err_nxt, ERR_TIME);
    if (e1) err_nxt = raise_err(err_nxt, ERR_MISMATCH);
    if (e2) err_nxt = raise_err(err_nxt, ERR_UNTIMED);
  end

  tlg_lerp #(.PW(PW), .TW(TIME_W)) u_lerp_x (
    .clk(clk), .load(cmd.eval), .step(cmd.div_step),
    .start_v(prev_x_r), .end_v(px_r), .num(num_r), .den(den_r), .res(lerp_x)
  );

  tlg_lerp #(.PW(PW), .TW(TIME_W)) u_lerp_y (
    .clk(clk), .load(cmd.eval), .step(cmd.div_step),
    .start_v(prev_y_r), .end_v(py_r), .num(num_r), .den(den_r), .res(lerp_y)
  );

  // root: two radicand bits per step
  logic [35:0] rem_sh, trial;
  logic [32:0] root_rnd;
  logic [31:0] root_sat;
  assign rem_sh   = {rem_r, rad_r[63:62]};
  assign trial    = {2'b00, root_r, 2'b01};
  assign root_rnd = {1'b0, root_r} + 33'((rem_r > {2'b00, root_r}));
  assign root_sat = (sat_r || root_rnd[32]) ? 32'hFFFF_FFFF : root_rnd[31:0];

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r    <= pt_x;
      py_r    <= pt_y;
      hd_r    <= pt_heading;
      timed_r <= pt_timed;
      last_r  <= pt_last;
      t_r     <= t_in;
      badt_r  <= pt_sec[15] || (pt_nsec >= NS_PER_SEC[29:0]);
    end
    prod_r <= {32'd0, mul_op} * {32'd0, mul_op};
    if (cmd.acc_ld) begin
      acc_r <= {1'b0, prod_r};
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + {1'b0, prod_r};
    end
    if (cmd.eval) begin
      num_r <= (lk_ext > prev_t_r) ? (lk_ext - prev_t_r) : '0;
      den_r <= t_r - prev_t_r;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.sq_init) begin
      rad_r   <= acc_r[63:0];
      rem_r   <= '0;
      root_r  <= '0;
      sqcnt_r <= '0;
      sat_r   <= acc_r[64] || big_goal;
    end else if (cmd.sq_step) begin
      rad_r   <= {rad_r[61:0], 2'b00};
      sqcnt_r <= sqcnt_r + 1'b1;
      if (rem_sh >= trial) begin
        rem_r  <= 34'(rem_sh - trial);
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[33:0];
        root_r <= {root_r[30:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      score_r <= (err_r == ERR_NONE && active_r) ? root_sat : 32'd0;
      oerr_r  <= err_r;
      oact_r  <= active_r;
    end
  end

  // trajectory state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      prev_hd_r    <= '0;
      prev_t_r     <= '0;
      proj_x_r     <= '0;
      proj_y_r     <= '0;
      proj_found_r <= 1'b0;
      first_r      <= 1'b1;
      untimed_r    <= 1'b0;
      err_r        <= ERR_NONE;
      active_r     <= 1'b0;
    end else begin
      if (cmd.act_latch) begin
        active_r <= !big_act && (acc_r <= {1'b0, prod_r});
      end
      if (cmd.eval) begin
        err_r   <= err_nxt;
        first_r <= 1'b0;
        if (timed_r) begin
          if (first_r) begin
            if (lk_le_t) begin
              proj_x_r     <= px_r;
              proj_y_r     <= py_r;
              proj_found_r <= 1'b1;
            end
          end else if (!proj_found_r && lk_le_t) begin
            // zero or negative span: take the end pose; otherwise the lanes fill it in
            if (!t_gt_prev) begin
              proj_x_r <= px_r;
              proj_y_r <= py_r;
            end
            proj_found_r <= 1'b1;
          end
          prev_x_r  <= px_r;
          prev_y_r  <= py_r;
          prev_hd_r <= hd_r;
          prev_t_r  <= t_r;
        end else begin
          untimed_r <= 1'b1;
        end
      end
      if (cmd.div_fin) begin
        proj_x_r <= lerp_x;
        proj_y_r <= lerp_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.first_point = first_r;
  assign sts.last        = last_r;
  assign sts.need_div    = need_div;
  assign sts.div_last    = (cnt_r == CW'(PW));
  assign sts.sq_last     = (sqcnt_r == 5'd31);
  assign sts.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_score  = score_r;
  assign out_err    = oerr_r;
  assign out_active = oact_r;

endmodule

>>> hw/rtl/trajectory_lookahead_goal_distance_top.sv
// Top level of the lookahead goal-distance scorer: register file, stream ports.
// Depends on tlg_pkg, tlg_ctrl and tlg_datapath.
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready  | in_tdata, in_tuser (has_time), in_tlast
//  out_    | out | out_tvalid / out_tready| out_tdata (score), out_tuser (code, active)
//  cfg_    | in  | psel, penable, pready  | paddr, pwdata (64 b), prdata
//
// Each point is accepted in idle and then evaluated; the first point of a
// trajectory also runs the shared squarer's activation test. A point that
// crosses the lookahead also runs the bit-serial interpolation lanes. The
// last point then squares the goal distance, loads and steps the two-bit root
// unit and loads the output register. A result waits in the output register
// and stalls only a later last point. Synchronous active-low reset; no clearing pass.
module trajectory_lookahead_goal_distance_top #(
  parameter  int POS_WIDTH = tlg_pkg::POS_WIDTH_DEF,
  localparam int IN_W      = ((2 * POS_WIDTH + 62 + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  // point_x, point_y, point_heading, time_sec, time_nanosec, zero pad
  input  logic [IN_W-1:0] in_tdata,
  // has_time
  input  logic [0:0]      in_tuser,
  input  logic            in_tlast,
  input  logic            in_tvalid,
  output logic            in_tready,
  // score
  output logic [31:0]     out_tdata,
  // error_code [1:0], scoring_active [2]
  output logic [2:0]      out_tuser,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  logic            cfg_psel,
  input  logic            cfg_penable,
  input  logic            cfg_pwrite,
  input  logic [5:0]      cfg_paddr,
  input  logic [63:0]     cfg_pwdata,
  output logic [63:0]     cfg_prdata,
  output logic            cfg_pready
);
  import tlg_pkg::*;

  localparam int PW = POS_WIDTH;

  logic [PW-1:0]   goal_x_r, goal_y_r, robot_x_r, robot_y_r;
  logic [31:0]     act_dist_r;
  logic [LK_W-1:0] lookahead_r;
  logic [2:0]      reg_idx;
  logic            cfg_wr;
  tlg_cmd_t        cmd;
  tlg_sts_t        sts;
  logic [1:0]      out_err;
  logic            out_active;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      robot_x_r   <= '0;
      robot_y_r   <= '0;
      act_dist_r  <= ACT_DIST_RESET;
      lookahead_r <= LOOKAHEAD_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GOAL_X:    goal_x_r    <= cfg_pwdata[PW-1:0];
        REG_GOAL_Y:    goal_y_r    <= cfg_pwdata[PW-1:0];
        REG_ROBOT_X:   robot_x_r   <= cfg_pwdata[PW-1:0];
        REG_ROBOT_Y:   robot_y_r   <= cfg_pwdata[PW-1:0];
        REG_ACT_DIST:  act_dist_r  <= cfg_pwdata[31:0];
        REG_LOOKAHEAD: lookahead_r <= cfg_pwdata[LK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GOAL_X:    cfg_prdata = 64'(goal_x_r);
      REG_GOAL_Y:    cfg_prdata = 64'(goal_y_r);
      REG_ROBOT_X:   cfg_prdata = 64'(robot_x_r);
      REG_ROBOT_Y:   cfg_prdata = 64'(robot_y_r);
      REG_ACT_DIST:  cfg_prdata = 64'(act_dist_r);
      REG_LOOKAHEAD: cfg_prdata = 64'(lookahead_r);
      default:       cfg_prdata = '0;
    endcase
  end

  tlg_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .sts(sts), .cmd(cmd)
  );

  tlg_datapath #(.PW(PW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .goal_x(goal_x_r), .goal_y(goal_y_r), .robot_x(robot_x_r), .robot_y(robot_y_r),
    .act_dist(act_dist_r), .lookahead(lookahead_r),
    .pt_x(in_tdata[PW-1:0]),
    .pt_y(in_tdata[2*PW-1:PW]),
    .pt_heading(in_tdata[2*PW+15:2*PW]),
    .pt_sec(in_tdata[2*PW+31:2*PW+16]),
    .pt_nsec(in_tdata[2*PW+61:2*PW+32]),
    .pt_timed(in_tuser[0]),
    .pt_last(in_tlast),
    .out_tready(out_tready), .out_tvalid(out_tvalid),
    .out_score(out_tdata), .out_err(out_err), .out_active(out_active)
  );

  assign out_tuser = {out_active, out_err};

endmodule
